### rtl/mirp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mirp_pkg: shared types and constants for the message id replay window
// Identifier width, verdict codes, the default window depth and the control
// group that the top level broadcasts to every window cell.
// -----------------------------------------------------------------------------
package mirp_pkg;

	localparam int unsigned ID_W         = 64;
	localparam int unsigned WINDOW_DEPTH = 64;

	typedef logic signed [ID_W-1:0] msg_id_t;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT    = 2'd0,
		VERDICT_DUPLICATE = 2'd1,
		VERDICT_TOO_OLD   = 2'd2
	} verdict_t;

	// Broadcast control from the sequencer to the cells
	typedef struct packed {
		logic cmp_en;   // register compare flags against the held key
		logic commit;   // apply the insert / evict shift
		logic full;     // window holds WINDOW_DEPTH entries
	} cell_ctrl_t;

endpackage : mirp_pkg
`default_nettype wire

### rtl/mirp_id_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mirp_id_if: identifier channel
// Valid/ready channel carrying one received message identifier per item.
// -----------------------------------------------------------------------------
interface mirp_id_if;
	logic                 valid;
	logic                 ready;
	mirp_pkg::msg_id_t    rx_id;

	modport source (output valid, output rx_id, input ready);
	modport sink   (input valid, input rx_id, output ready);
endinterface : mirp_id_if
`default_nettype wire

### rtl/mirp_verdict_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mirp_verdict_if: verdict channel
// Valid/ready channel carrying one 2-bit verdict per item.
// -----------------------------------------------------------------------------
interface mirp_verdict_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source (output valid, output verdict, input ready);
	modport sink   (input valid, input verdict, output ready);
endinterface : mirp_verdict_if
`default_nettype wire

### rtl/message_id_replay_window.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// message_id_replay_window: anti-replay filter over message identifiers
// Keeps the newest accepted identifiers sorted in a row of cells, rejects
// duplicates and identifiers older than a full window, evicts the oldest.
//
//   channel       dir   payload                 handshake
//   id_chan       in    rx_id       s64         valid / ready
//   verdict_chan  out   verdict     u2          valid / ready
//
// One item at a time: accept, compare in all cells, then decide and shift.
// The verdict is registered as the decide state ends, and ready returns in
// the same cycle, so a new identifier is taken only once the last is decided.
// The verdict sits in an output register, so a stalled verdict does not block
// the next accept; a new decision waits only while that register is full.
// Reset empties the window (held count zero); no clearing pass is needed.
// -----------------------------------------------------------------------------
module message_id_replay_window #(
	parameter int unsigned WindowDepth = mirp_pkg::WINDOW_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	mirp_id_if.sink        id_chan,
	mirp_verdict_if.source verdict_chan
);

	localparam int unsigned CntW = $clog2(WindowDepth + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_DEC  = 3'b100
	} state_t;

	state_t               state_q;
	mirp_pkg::msg_id_t    key_q;
	logic [CntW-1:0]      count_q;
	logic                 out_valid_q;
	mirp_pkg::verdict_t   verdict_q;

	mirp_pkg::cell_ctrl_t ctrl;
	mirp_pkg::verdict_t   verdict_nxt;
	mirp_pkg::msg_id_t    entry [WindowDepth];
	logic [WindowDepth-1:0] lt_vec;
	logic [WindowDepth-1:0] eq_vec;
	logic [WindowDepth-1:0] valid_vec;
	logic                 in_acc;
	logic                 dec_go;
	logic                 full;

	assign in_acc = id_chan.valid && id_chan.ready;
	assign full   = (count_q == CntW'(WindowDepth));
	assign dec_go = (state_q == ST_DEC) && (!out_valid_q || verdict_chan.ready);

	// Verdict from the registered compare flags
	always_comb begin
		if (full && !lt_vec[0] && !eq_vec[0])
			verdict_nxt = mirp_pkg::VERDICT_TOO_OLD;
		else if (|eq_vec)
			verdict_nxt = mirp_pkg::VERDICT_DUPLICATE;
		else
			verdict_nxt = mirp_pkg::VERDICT_ACCEPT;
	end

	always_comb begin
		ctrl.cmp_en = (state_q == ST_CMP);
		ctrl.commit = dec_go && (verdict_nxt == mirp_pkg::VERDICT_ACCEPT);
		ctrl.full   = full;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (dec_go)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			key_q <= id_chan.rx_id;
	end

	// Held count grows until the window is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (ctrl.commit && !full)
			count_q <= count_q + CntW'(1);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (dec_go)
			out_valid_q <= 1'b1;
		else if (verdict_chan.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (dec_go)
			verdict_q <= verdict_nxt;
	end

	assign id_chan.ready        = (state_q == ST_IDLE);
	assign verdict_chan.valid   = out_valid_q;
	assign verdict_chan.verdict = verdict_q;

	// Row of cells; the ends see a lower neighbor that is always below the
	// key and an upper neighbor that never is
	for (genvar i = 0; i < WindowDepth; i++) begin : g_cell
		mirp_pkg::msg_id_t lo_entry;
		mirp_pkg::msg_id_t hi_entry;
		logic              lo_lt;
		logic              hi_lt;

		assign valid_vec[i] = (CntW'(i) < count_q);

		if (i == 0) begin : g_lo_end
			assign lo_entry = key_q;
			assign lo_lt    = 1'b1;
		end else begin : g_lo
			assign lo_entry = entry[i-1];
			assign lo_lt    = lt_vec[i-1];
		end

		if (i == WindowDepth - 1) begin : g_hi_end
			assign hi_entry = key_q;
			assign hi_lt    = 1'b0;
		end else begin : g_hi
			assign hi_entry = entry[i+1];
			assign hi_lt    = lt_vec[i+1];
		end

		mirp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.key      (key_q),
			.valid    (valid_vec[i]),
			.lo_entry (lo_entry),
			.lo_lt    (lo_lt),
			.hi_entry (hi_entry),
			.hi_lt    (hi_lt),
			.entry    (entry[i]),
			.lt       (lt_vec[i]),
			.eq       (eq_vec[i])
		);
	end

endmodule : message_id_replay_window
`default_nettype wire

### rtl/mirp_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mirp_cell: one slot of the sorted identifier window
// Holds one identifier, compares it against the broadcast key and, on commit,
// keeps its value, takes the key, or takes a neighbor's value.
// -----------------------------------------------------------------------------
module mirp_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mirp_pkg::cell_ctrl_t ctrl,
	input  wire mirp_pkg::msg_id_t    key,
	input  wire logic                 valid,     // slot index below held count
	input  wire mirp_pkg::msg_id_t    lo_entry,  // neighbor one slot down
	input  wire logic                 lo_lt,
	input  wire mirp_pkg::msg_id_t    hi_entry,  // neighbor one slot up
	input  wire logic                 hi_lt,
	output mirp_pkg::msg_id_t         entry,
	output logic                      lt,
	output logic                      eq
);

	mirp_pkg::msg_id_t entry_q;
	mirp_pkg::msg_id_t entry_nxt;
	logic              lt_q;
	logic              eq_q;

	// Compare flags, only meaningful for held slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			lt_q <= valid && (entry_q < key);
			eq_q <= valid && (entry_q == key);
		end
	end

	// Next value on commit
	always_comb begin
		entry_nxt = entry_q;
		if (ctrl.full) begin
			// evict bottom: slots below the insert point move down
			if (hi_lt)
				entry_nxt = hi_entry;
			else if (lt_q)
				entry_nxt = key;
		end else begin
			// grow: slots at or above the insert point move up
			if (!lt_q)
				entry_nxt = lo_lt ? key : lo_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit)
			entry_q <= entry_nxt;
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule : mirp_cell
`default_nettype wire

### rtl/mirp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mirp_checker: port-level checks for the replay window
// Watches both channels of the top level; bound in below.
// -----------------------------------------------------------------------------
module mirp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] verdict
);

	// A stalled verdict stays offered and unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict))
		else $error("verdict dropped or changed while stalled");

	// Only defined verdict codes leave the block
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == mirp_pkg::VERDICT_ACCEPT ||
			verdict == mirp_pkg::VERDICT_DUPLICATE ||
			verdict == mirp_pkg::VERDICT_TOO_OLD))
		else $error("undefined verdict code");

	// One item in flight: after an accept, ready stays low in the compare and decide states
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("item accepted while another is in flight");

	// Ready returns after the decide state when the output is free at the accept and ready at decide
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> ##1 out_ready |=> in_ready)
		else $error("block did not return to ready");

endmodule : mirp_checker

bind message_id_replay_window mirp_checker u_mirp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (id_chan.valid),
	.in_ready  (id_chan.ready),
	.out_valid (verdict_chan.valid),
	.out_ready (verdict_chan.ready),
	.verdict   (verdict_chan.verdict)
);
`default_nettype wire
